// ----- sv/rlqa_pkg.sv -----
package rlqa_pkg;

    localparam int ACTION_W = 1;
    localparam int NODE_W   = 4;
    localparam int REQ_W    = 7;
    localparam int PRI_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = PRI_W + REQ_W;

    localparam logic [ACTION_W-1:0] ACT_ARRIVE = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_LEAVE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GRANT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic scan;
        logic shift;
        logic commit;
        logic push;
    } ctl_cmd_t;

    typedef struct packed {
        logic dec_grant;
        logic scan_done;
        logic shift_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/rlqa_req_if.sv -----
interface rlqa_req_if;
    logic                          valid;
    logic                          ready;
    logic [rlqa_pkg::ACTION_W-1:0] action;
    logic [rlqa_pkg::NODE_W-1:0]   node;
    logic [rlqa_pkg::REQ_W-1:0]    requester;
    logic [rlqa_pkg::PRI_W-1:0]    priority_req;

    modport source (
        output valid, action, node, requester, priority_req,
        input  ready
    );

    modport sink (
        input  valid, action, node, requester, priority_req,
        output ready
    );
endinterface

// ----- sv/rlqa_rsp_if.sv -----
interface rlqa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rlqa_pkg::STATUS_W-1:0] status;
    logic [rlqa_pkg::REQ_W-1:0]    granted_requester;
    logic [rlqa_pkg::NODE_W-1:0]   granted_node;

    modport source (
        output valid, status, granted_requester, granted_node,
        input  ready
    );

    modport sink (
        input  valid, status, granted_requester, granted_node,
        output ready
    );
endinterface

// ----- sv/rlqa_ctrl.sv -----
module rlqa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  rlqa_pkg::dp_status_t  stat,
    output logic                  in_ready,
    output rlqa_pkg::ctl_cmd_t    cmd
);

    rlqa_pkg::state_t state_reg;
    rlqa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlqa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlqa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rlqa_pkg::S_DECIDE;
                end
            end
            rlqa_pkg::S_DECIDE:
            begin
                state_next = stat.dec_grant ? rlqa_pkg::S_SCAN : rlqa_pkg::S_RESULT;
            end
            rlqa_pkg::S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = rlqa_pkg::S_SHIFT;
                end
            end
            rlqa_pkg::S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = rlqa_pkg::S_RESULT;
                end
            end
            rlqa_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = rlqa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rlqa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            rlqa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = req_valid;
            end
            rlqa_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            rlqa_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            rlqa_pkg::S_SHIFT:
            begin
                cmd.shift  = !stat.shift_done;
                cmd.commit = stat.shift_done;
            end
            rlqa_pkg::S_RESULT:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/rlqa_dpath.sv -----
module rlqa_dpath #(
    parameter int NODES       = 16,
    parameter int REQUESTERS  = 128,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlqa_pkg::ctl_cmd_t            cmd,
    output rlqa_pkg::dp_status_t          stat,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic [rlqa_pkg::ACTION_W-1:0] in_action,
    input  logic [rlqa_pkg::NODE_W-1:0]   in_node,
    input  logic [rlqa_pkg::REQ_W-1:0]    in_requester,
    input  logic [rlqa_pkg::PRI_W-1:0]    in_priority,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [rlqa_pkg::STATUS_W-1:0] out_status,
    output logic [rlqa_pkg::REQ_W-1:0]    out_requester,
    output logic [rlqa_pkg::NODE_W-1:0]   out_node
);

    localparam int NIDX_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH  = NODES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] QD_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);

    // item registers
    logic [rlqa_pkg::ACTION_W-1:0] action_reg;
    logic [rlqa_pkg::NODE_W-1:0]   node_reg;
    logic [rlqa_pkg::REQ_W-1:0]    req_reg;
    logic [rlqa_pkg::PRI_W-1:0]    pri_reg;

    logic                          mode_reg;
    logic [CNT_W-1:0]              cnt_reg [NODES];
    logic                          busy_reg [NODES];

    logic [rlqa_pkg::ENTRY_W-1:0]  mem [DEPTH];
    logic [rlqa_pkg::ENTRY_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0]              gcnt_reg;
    logic [CNT_W-1:0]              issue_reg;
    logic                          cmp_v_reg;
    logic [CNT_W-1:0]              cmp_idx_reg;
    logic [CNT_W-1:0]              pick_reg;
    logic [rlqa_pkg::PRI_W-1:0]    best_reg;
    logic [rlqa_pkg::REQ_W-1:0]    who_reg;
    logic [CNT_W-1:0]              sr_reg;
    logic                          wv_reg;
    logic [CNT_W-1:0]              wj_reg;
    logic [rlqa_pkg::STATUS_W-1:0] res_status_reg;

    logic                          out_valid_reg;
    logic [rlqa_pkg::STATUS_W-1:0] out_status_reg;
    logic [rlqa_pkg::REQ_W-1:0]    out_req_reg;
    logic [rlqa_pkg::NODE_W-1:0]   out_node_reg;

    logic [NIDX_W-1:0]             nidx;
    logic [CNT_W-1:0]              cur_cnt;
    logic                          node_ok;
    logic                          req_ok;
    logic                          arrive;
    logic                          full;
    logic                          dec_write;
    logic                          dec_drop;
    logic                          dec_grant;
    logic [CNT_W-1:0]              lim;
    logic                          scan_issue;
    logic                          take;
    logic [CNT_W-1:0]              pick_next;
    logic                          scan_done;
    logic                          sh_issue;
    logic                          shift_done;
    logic                          out_free;
    logic [ADDR_W-1:0]             base_addr;
    logic                          rd_en;
    logic [CNT_W-1:0]              rd_idx;
    logic                          wr_en;
    logic [CNT_W-1:0]              wr_idx;
    logic [rlqa_pkg::ENTRY_W-1:0]  wr_data;
    logic [rlqa_pkg::PRI_W-1:0]    rd_pri;
    logic [rlqa_pkg::REQ_W-1:0]    rd_id;

    assign nidx      = NIDX_W'(node_reg);
    assign cur_cnt   = cnt_reg[nidx];
    assign node_ok   = int'(node_reg) < NODES;
    assign req_ok    = int'(req_reg) < REQUESTERS;
    assign arrive    = action_reg == rlqa_pkg::ACT_ARRIVE;
    assign full      = cur_cnt >= QD_CNT;
    assign dec_write = node_ok && arrive && req_ok && !full;
    assign dec_drop  = node_ok && arrive && req_ok && full;
    assign dec_grant = node_ok && (arrive ? (dec_write && !busy_reg[nidx])
                                          : (cur_cnt != '0));

    assign rd_pri = rd_data_reg[rlqa_pkg::ENTRY_W-1:rlqa_pkg::REQ_W];
    assign rd_id  = rd_data_reg[rlqa_pkg::REQ_W-1:0];

    // first come first served looks at the head only
    assign lim        = mode_reg ? gcnt_reg : ONE;
    assign scan_issue = cmd.scan && (issue_reg < lim);
    assign take       = cmd.scan && cmp_v_reg &&
                        ((cmp_idx_reg == '0) || (mode_reg && (rd_pri > best_reg)));
    assign pick_next  = take ? cmp_idx_reg : pick_reg;
    assign scan_done  = cmp_v_reg && (cmp_idx_reg == (lim - ONE));

    assign sh_issue   = cmd.shift && (sr_reg < gcnt_reg);
    assign shift_done = !(sr_reg < gcnt_reg) && !wv_reg;

    assign out_free   = !out_valid_reg || out_ready;

    assign stat.dec_grant  = dec_grant;
    assign stat.scan_done  = scan_done;
    assign stat.shift_done = shift_done;
    assign stat.out_free   = out_free;

    assign base_addr = ADDR_W'(node_reg) * ADDR_W'(QUEUE_DEPTH);
    assign rd_en     = scan_issue || sh_issue;
    assign rd_idx    = cmd.scan ? issue_reg : sr_reg;
    assign wr_en     = (cmd.decide && dec_write) || (cmd.shift && wv_reg);
    assign wr_idx    = cmd.decide ? cur_cnt : wj_reg;
    assign wr_data   = cmd.decide ? {pri_reg, req_reg} : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[base_addr + ADDR_W'(wr_idx)] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[base_addr + ADDR_W'(rd_idx)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            action_reg <= rlqa_pkg::ACT_ARRIVE;
            node_reg   <= '0;
            req_reg    <= '0;
            pri_reg    <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                cnt_reg[i]  <= '0;
                busy_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                action_reg <= in_action;
                node_reg   <= in_node;
                req_reg    <= in_requester;
                pri_reg    <= in_priority;
            end
            if (cmd.decide)
            begin
                if (dec_write)
                begin
                    cnt_reg[nidx] <= cur_cnt + ONE;
                end
                if (node_ok && !arrive)
                begin
                    busy_reg[nidx] <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                cnt_reg[nidx]  <= gcnt_reg - ONE;
                busy_reg[nidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= '0;
            cmp_v_reg      <= 1'b0;
            wv_reg         <= 1'b0;
            sr_reg         <= '0;
            gcnt_reg       <= '0;
            res_status_reg <= rlqa_pkg::STATUS_NONE;
        end
        else
        begin
            if (cmd.decide)
            begin
                gcnt_reg       <= arrive ? cur_cnt + ONE : cur_cnt;
                issue_reg      <= '0;
                cmp_v_reg      <= 1'b0;
                res_status_reg <= dec_drop ? rlqa_pkg::STATUS_DROP : rlqa_pkg::STATUS_NONE;
            end
            if (cmd.scan)
            begin
                if (scan_issue)
                begin
                    issue_reg <= issue_reg + ONE;
                end
                cmp_v_reg <= scan_issue;
                if (scan_done)
                begin
                    // start the shift just past the chosen entry
                    sr_reg <= pick_next + ONE;
                    wv_reg <= 1'b0;
                end
            end
            if (cmd.shift)
            begin
                if (sh_issue)
                begin
                    sr_reg <= sr_reg + ONE;
                end
                wv_reg <= sh_issue;
            end
            if (cmd.commit)
            begin
                res_status_reg <= rlqa_pkg::STATUS_GRANT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            cmp_idx_reg <= issue_reg;
        end
        if (take)
        begin
            best_reg <= rd_pri;
            who_reg  <= rd_id;
            pick_reg <= cmp_idx_reg;
        end
        if (sh_issue)
        begin
            wj_reg <= sr_reg - ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            if (res_status_reg == rlqa_pkg::STATUS_GRANT)
            begin
                out_req_reg  <= who_reg;
                out_node_reg <= node_reg;
            end
            else
            begin
                out_req_reg  <= '0;
                out_node_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_requester = out_req_reg;
    assign out_node      = out_node_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_ok |-> cur_cnt <= QD_CNT)
        else $error("queue count above depth");

    a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> gcnt_reg != '0)
        else $error("grant committed from an empty queue");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> out_free)
        else $error("result word overwritten before it was taken");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> sr_reg <= gcnt_reg)
        else $error("shift pointer ran past the queue");

endmodule

// ----- sv/resource_lock_queue_arbiter_core.sv -----
// channel | dir | fields                                       | handshake
// req     | in  | action, node, requester, priority_req        | valid/ready
// rsp     | out | status, granted_requester, granted_node      | valid/ready
// cfg     | in  | cfg_wdata (mode)                             | cfg_we, no wait
//
// One request at a time: with no grant a request passes decide and result states.
// A grant adds a scan of the queue (the head only in first come first served mode)
// and an order-keeping shift of the later entries, none if the last one is picked.
// Both walks go through the single read and single write port of the entry memory.
// Reset clears mode, queue counts and busy flags at once; no clearing pass.
// A result waits in the output register; the next result holds until it drains.
module resource_lock_queue_arbiter_core #(
    parameter int NODES       = 16,
    parameter int REQUESTERS  = 128,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    rlqa_req_if.sink          req,
    rlqa_rsp_if.source        rsp
);

    rlqa_pkg::ctl_cmd_t   cmd;
    rlqa_pkg::dp_status_t stat;
    logic                 in_ready;

    assign req.ready = in_ready;

    rlqa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    rlqa_dpath #(
        .NODES       (NODES),
        .REQUESTERS  (REQUESTERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_action     (req.action),
        .in_node       (req.node),
        .in_requester  (req.requester),
        .in_priority   (req.priority_req),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .out_status    (rsp.status),
        .out_requester (rsp.granted_requester),
        .out_node      (rsp.granted_node)
    );

endmodule
